FILE: design/j2_plastic_return_update_top_defines.svh
// Assertion macros for the J2 plastic return block.
// Used by the top level only; expects clk and rst in scope.
`ifndef J2_PLASTIC_RETURN_UPDATE_TOP_DEFINES_SVH
`define J2_PLASTIC_RETURN_UPDATE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define J2PR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("j2pr assertion failed");

// Next-cycle implication, disabled during reset.
`define J2PR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("j2pr assertion failed");

`endif

FILE: design/j2pr_pkg.sv
// Shared types and constants of the J2 plastic return block.
// No dependencies.
`default_nettype none

package j2pr_pkg;

  localparam int MW = 34;            // serial multiplier operand width
  localparam int PW = 2 * MW + 2;    // product / accumulator width
  localparam int RW = 6 * 32 + 31;   // store row: six strains and equiv

  localparam logic [29:0] SQRT23_Q30 = 30'd876706528;
  localparam logic [29:0] HALF_Q30   = 30'd536870912;
  localparam logic [30:0] MAX31      = 31'h7fffffff;

  typedef struct packed {
    logic start;
    logic clr;
  } mul_ctl_t;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_LOAD  = 12'b000000000100,
    S_SQ    = 12'b000000001000,
    S_SQRT  = 12'b000000010000,
    S_HQ    = 12'b000000100000,
    S_T     = 12'b000001000000,
    S_DL    = 12'b000010000000,
    S_DE    = 12'b000100000000,
    S_N     = 12'b001000000000,
    S_D     = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_t;

endpackage

`default_nettype wire

FILE: design/j2pr_mul.sv
// Bit-serial shift-add multiplier with an accumulating product register.
// Depends on j2pr_pkg.
`default_nettype none

module j2pr_mul import j2pr_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mul_ctl_t      ctl,
  input  wire logic [MW-1:0] a,
  input  wire logic [MW-1:0] b,
  output logic               busy,
  output logic [PW-1:0]      acc
);

  logic [PW-1:0] areg;
  logic [MW-1:0] breg;

  assign busy = (breg != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      breg <= '0;
    end else if (ctl.start) begin
      areg <= PW'(a);
      breg <= b;
      if (ctl.clr) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (breg[0]) begin
        acc <= acc + areg;
      end
      areg <= {areg[PW-2:0], 1'b0};
      breg <= {1'b0, breg[MW-1:1]};
    end
  end

endmodule

`default_nettype wire

FILE: design/j2pr_sqrt.sv
// Integer square root by digit recurrence, two radicand bits per cycle.
// Depends on j2pr_pkg.
`default_nettype none

module j2pr_sqrt import j2pr_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [PW-1:0]   rad,
  output logic                 busy,
  output logic [PW/2-1:0]      root
);

  localparam int NW = PW / 2;

  logic [PW-1:0]   rad_r;
  logic [NW+1:0]   rem;
  logic [5:0]      cnt;
  logic [NW+3:0]   rem2;
  logic [NW+3:0]   trial;
  logic [NW+3:0]   rdiff;

  assign busy  = (cnt != '0);
  assign rem2  = {rem, rad_r[PW-1:PW-2]};
  assign trial = {2'b00, root, 2'b01};
  assign rdiff = rem2 - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      rad_r <= rad;
      rem   <= '0;
      root  <= '0;
      cnt   <= 6'(NW);
    end else if (busy) begin
      if (rem2 >= trial) begin
        // The remainder never exceeds twice the root, so it fits.
        rem  <= rdiff[NW+1:0];
        root <= {root[NW-2:0], 1'b1};
      end else begin
        rem  <= rem2[NW+1:0];
        root <= {root[NW-2:0], 1'b0};
      end
      rad_r <= {rad_r[PW-3:0], 2'b00};
      cnt   <= cnt - 6'd1;
    end
  end

endmodule

`default_nettype wire

FILE: design/j2pr_div.sv
// Restoring fraction divider: min(floor(num * 2^30 / den), 2^31-1), one bit a cycle.
// Depends on j2pr_pkg.
`default_nettype none

module j2pr_div import j2pr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [35:0] num,
  input  wire logic [35:0] den,
  output logic             busy,
  output logic [30:0]      q
);

  logic [36:0] rem;
  logic [35:0] den_r;
  logic [4:0]  cnt;
  logic        ge;
  logic [36:0] diff;

  assign busy = (cnt != '0);
  assign ge   = (rem >= {1'b0, den_r});
  assign diff = ge ? (rem - {1'b0, den_r}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      den_r <= den;
      if ({1'b0, num} >= {den, 1'b0}) begin
        // Quotient of two or more saturates at once.
        q   <= MAX31;
        cnt <= '0;
      end else begin
        rem <= {1'b0, num};
        q   <= '0;
        cnt <= 5'd31;
      end
    end else if (busy) begin
      rem <= {diff[35:0], 1'b0};
      q   <= {q[29:0], ge};
      cnt <= cnt - 5'd1;
    end
  end

endmodule

`default_nettype wire

FILE: design/j2_plastic_return_update_top.sv
// J2 radial return with linear hardening, one grid point per request.
// Its duration is set by the serial multiplier (six squares, the hardening, yield and
// equivalent-strain products, one product per strain), the square root, the flow divide
// and the six normalizing divisions; a non-yielding point stops after the yield term.
// Throughput: one request at a time, the next is taken once the result is registered.
// Reset is synchronous; afterwards a clearing pass zeroes all min(POINTS, 4096) rows of
// the point store before the first request is accepted.
`default_nettype none
`include "j2_plastic_return_update_top_defines.svh"

module j2_plastic_return_update_top import j2pr_pkg::*; #(
  parameter int POINTS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [11:0]        point_index,
  input  wire logic signed [31:0] stress_xx,
  input  wire logic signed [31:0] stress_yy,
  input  wire logic signed [31:0] stress_zz,
  input  wire logic signed [31:0] stress_yz,
  input  wire logic signed [31:0] stress_xz,
  input  wire logic signed [31:0] stress_xy,
  input  wire logic [30:0]        point_yield,
  input  wire logic [30:0]        point_hardening,
  input  wire logic [30:0]        point_shear,
  input  wire logic               last_point,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      plastic_xx,
  output logic signed [31:0]      plastic_yy,
  output logic signed [31:0]      plastic_zz,
  output logic signed [31:0]      plastic_yz,
  output logic signed [31:0]      plastic_xz,
  output logic signed [31:0]      plastic_xy,
  output logic [30:0]             equiv_plastic,
  output logic                    yielded,
  output logic                    flow_error,
  output logic [30:0]             max_delta_strain,
  output logic [30:0]             max_delta_equiv,
  output logic                    sweep_done
);

  // The 12-bit index reaches at most 4096 rows, so the store never needs more.
  localparam int DEPTH = (POINTS < 4096) ? POINTS : 4096;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Round half up after a 30-bit shift.
  function automatic logic [39:0] rnd30(input logic [PW-1:0] p);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(HALF_Q30);
    return s[69:30];
  endfunction

  state_t state, state_next;

  // Captured request.
  logic [11:0]        idx_r;
  logic               inr_r;
  logic signed [31:0] s_r [6];
  logic [30:0]        y_r, h_r, g_r;
  logic               last_r;

  // Deviatoric stress in thirds of an LSB: magnitude and sign per component.
  logic [MW-1:0]      dmag [6];
  logic               dneg [6];

  // Store row read for this point; out-of-range points read as zero.
  logic [RW-1:0]      mem [DEPTH];
  logic [RW-1:0]      rd_row;
  logic [AW-1:0]      clr_cnt;

  logic [34:0]        r_root;
  logic [32:0]        hq;
  logic [30:0]        dl;
  logic [30:0]        nq;
  logic signed [31:0] newv [6];
  logic [30:0]        newep;
  logic               yld_r, err_r;
  logic [2:0]         k;
  logic               launched;
  logic [30:0]        run_max_s, run_max_e;

  // Arithmetic units.
  mul_ctl_t           mctl;
  logic [MW-1:0]      mul_a, mul_b;
  logic               mul_busy;
  logic [PW-1:0]      mul_acc;
  logic               sq_start, sq_busy;
  logic [34:0]        sq_root;
  logic               dv_start, dv_busy;
  logic [35:0]        dv_num, dv_den;
  logic [30:0]        dv_q;

  logic               units_idle;
  logic               step_done;
  logic               fin_go;
  logic [30:0]        old_ep;
  logic [31:0]        old_k;
  logic [35:0]        div3;
  logic [39:0]        acc_rnd;
  logic [32:0]        t_now;
  logic [37:0]        f3_now;
  logic               yld_now;
  logic [30:0]        de_now;
  logic [31:0]        ep_sum;
  logic [30:0]        ep_new;
  logic [30:0]        ep_delta;
  logic [31:0]        d_now;
  logic [33:0]        v_sum;
  logic [31:0]        v_new;
  logic [33:0]        v_diff;
  logic [33:0]        v_abs;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [RW-1:0]      mem_wd;
  logic signed [33:0] ssum;

  assign in_stall   = (state != S_IDLE);
  assign units_idle = !mul_busy && !sq_busy && !dv_busy;
  assign step_done  = launched && units_idle;
  assign fin_go     = (state == S_FIN) && (!out_valid || !out_stall);
  assign old_ep     = rd_row[RW-1:192];
  assign old_k      = rd_row[{k, 5'b0} +: 32];

  // Deviatoric parts: normal components subtract the trace.
  always_comb begin
    logic signed [35:0] dv;
    ssum = 34'(s_r[0]) + 34'(s_r[1]) + 34'(s_r[2]);
    for (int i = 0; i < 6; i++) begin
      dv = 36'(s_r[i]) * 36'sd3;
      if (i < 3) begin
        dv = dv - 36'(ssum);
      end
      dneg[i] = dv[35];
      dmag[i] = dv[35] ? MW'(-dv) : MW'(dv);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mctl.start = 1'b0;
    mctl.clr   = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_SQ: begin
        mctl.start = !launched;
        mctl.clr   = (k == 3'd0);
        mul_a      = dmag[k];
        mul_b      = dmag[k];
      end
      S_HQ: begin
        mctl.start = !launched;
        mul_a      = MW'(h_r);
        mul_b      = MW'(old_ep);
      end
      S_T: begin
        mctl.start = !launched;
        mul_a      = MW'(y_r) + MW'(hq);
        mul_b      = MW'(SQRT23_Q30);
      end
      S_DE: begin
        mctl.start = !launched;
        mul_a      = MW'(SQRT23_Q30);
        mul_b      = MW'(dl);
      end
      S_D: begin
        mctl.start = !launched;
        mul_a      = MW'(nq);
        mul_b      = MW'(dl);
      end
      default: begin
        mctl.start = 1'b0;
      end
    endcase
  end

  assign sq_start = (state == S_SQRT) && !launched;
  assign dv_start = ((state == S_DL) || (state == S_N)) && !launched;
  assign div3     = 36'({g_r, 2'b00}) + 36'({g_r, 1'b0}) + 36'({h_r, 1'b0});
  assign dv_num   = (state == S_DL) ? f3_now[35:0] : 36'(dmag[k]);
  assign dv_den   = (state == S_DL) ? div3 : 36'(r_root);

  // The product register keeps the hardened yield term until the flow divide starts,
  // so the yield margin stays valid through the first cycle of the divide.
  assign acc_rnd = rnd30(mul_acc);
  assign t_now   = acc_rnd[32:0];
  assign f3_now  = 38'(r_root) - (38'(t_now) + 38'({t_now, 1'b0}));
  assign yld_now = !f3_now[37] && (f3_now != '0);

  // Equivalent strain update, saturated.
  assign de_now   = acc_rnd[30:0];
  assign ep_sum   = {1'b0, old_ep} + {1'b0, de_now};
  assign ep_new   = ep_sum[31] ? MAX31 : ep_sum[30:0];
  assign ep_delta = ep_new - old_ep;

  // One strain component: add the signed increment and saturate to 32 bits.
  assign d_now  = acc_rnd[31:0];
  assign v_sum  = dneg[k] ? (34'(signed'(old_k)) - 34'(d_now))
                          : (34'(signed'(old_k)) + 34'(d_now));
  assign v_new  = (!v_sum[33] && (v_sum[32:31] != 2'b00)) ? 32'h7fffffff :
                  (v_sum[33] && (v_sum[32:31] != 2'b11)) ? 32'h80000000 : v_sum[31:0];
  assign v_diff = 34'(signed'(v_new)) - 34'(signed'(old_k));
  assign v_abs  = v_diff[33] ? -v_diff : v_diff;

  j2pr_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mctl),
    .a    (mul_a),
    .b    (mul_b),
    .busy (mul_busy),
    .acc  (mul_acc)
  );

  j2pr_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (mul_acc),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  j2pr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .busy  (dv_busy),
    .q     (dv_q)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == AW'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_LOAD;
      S_LOAD:  state_next = S_SQ;
      S_SQ:    if (step_done && (k == 3'd5)) state_next = S_SQRT;
      S_SQRT:  if (step_done) state_next = S_HQ;
      S_HQ:    if (step_done) state_next = S_T;
      S_T: begin
        if (step_done) begin
          state_next = (yld_now && (div3 != '0)) ? S_DL : S_FIN;
        end
      end
      S_DL:    if (step_done) state_next = S_DE;
      S_DE:    if (step_done) state_next = S_N;
      S_N:     if (step_done) state_next = S_D;
      S_D:     if (step_done) state_next = (k == 3'd5) ? S_FIN : S_N;
      S_FIN:   if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      launched  <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
      run_max_s <= '0;
      run_max_e <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == S_SQ || state == S_SQRT || state == S_HQ || state == S_T ||
          state == S_DL || state == S_DE || state == S_N || state == S_D) begin
        launched <= !step_done;
      end
      if ((state == S_SQ || state == S_D) && step_done) begin
        k <= (k == 3'd5) ? 3'd0 : k + 3'd1;
      end
      if (state == S_DE && step_done && (ep_delta > run_max_e)) begin
        run_max_e <= ep_delta;
      end
      if (state == S_D && step_done && (v_abs[30:0] > run_max_s)) begin
        run_max_s <= v_abs[30:0];
      end
      if (fin_go) begin
        out_valid <= 1'b1;
        if (last_r) begin
          run_max_s <= '0;
          run_max_e <= '0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      idx_r  <= point_index;
      inr_r  <= (32'(point_index) < 32'(POINTS));
      s_r[0] <= stress_xx;
      s_r[1] <= stress_yy;
      s_r[2] <= stress_zz;
      s_r[3] <= stress_yz;
      s_r[4] <= stress_xz;
      s_r[5] <= stress_xy;
      y_r    <= point_yield;
      h_r    <= point_hardening;
      g_r    <= point_shear;
      last_r <= last_point;
    end
    if (state == S_LOAD) begin
      rd_row <= inr_r ? mem[idx_r[AW-1:0]] : '0;
    end
    if (state == S_SQRT && step_done) begin
      r_root <= sq_root;
    end
    if (state == S_HQ && !launched) begin
      // Without a flow the point keeps what the store held.
      for (int i = 0; i < 6; i++) begin
        newv[i] <= rd_row[32*i +: 32];
      end
      newep <= old_ep;
    end
    if (state == S_HQ && step_done) begin
      hq <= acc_rnd[32:0];
    end
    if (state == S_T && step_done) begin
      yld_r <= yld_now;
      err_r <= yld_now && (div3 == '0);
    end
    if (state == S_DL && step_done) begin
      dl <= dv_q;
    end
    if (state == S_DE && step_done) begin
      newep <= ep_new;
    end
    if (state == S_N && step_done) begin
      nq <= dv_q;
    end
    if (state == S_D && step_done) begin
      newv[k] <= v_new;
    end
    if (fin_go) begin
      plastic_xx       <= newv[0];
      plastic_yy       <= newv[1];
      plastic_zz       <= newv[2];
      plastic_yz       <= newv[3];
      plastic_xz       <= newv[4];
      plastic_xy       <= newv[5];
      equiv_plastic    <= newep;
      yielded          <= yld_r;
      flow_error       <= err_r;
      max_delta_strain <= run_max_s;
      max_delta_equiv  <= run_max_e;
      sweep_done       <= last_r;
    end
  end

  // Point store: the clearing pass after reset, then one row write per in-range point.
  assign mem_we = (state == S_CLEAR) || (fin_go && inr_r);
  assign mem_wa = (state == S_CLEAR) ? clr_cnt : idx_r[AW-1:0];
  assign mem_wd = (state == S_CLEAR) ? '0 :
                  {newep, newv[5], newv[4], newv[3], newv[2], newv[1], newv[0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // A taken request keeps the input side stalled until its result is registered.
  `J2PR_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  // An update skipped for a zero divisor only happens on a yielding point.
  `J2PR_ASSERT_NOW(a_err_needs_yield, out_valid && flow_error, yielded)
  // The end of a sweep leaves both running maxima cleared.
  `J2PR_ASSERT_NEXT(a_sweep_clear, fin_go && last_r, run_max_s == '0 && run_max_e == '0)

endmodule

`default_nettype wire
